>>> src/crc8_multi_model_engine_core_macros.svh
// assertion macros for the crc-8 multi-model engine
`ifndef CRC8_MULTI_MODEL_ENGINE_CORE_MACROS_SVH
`define CRC8_MULTI_MODEL_ENGINE_CORE_MACROS_SVH

// same-cycle implication, checked on clk, quiet during reset
`define CRC8MM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crc8mm same-cycle check failed");

// next-cycle implication, checked on clk, quiet during reset
`define CRC8MM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crc8mm next-cycle check failed");

`endif

>>> src/crc8mm_pkg.sv
// types, model table and bit functions for the crc-8 multi-model engine
package crc8mm_pkg;

	localparam int CRC_W   = 8;
	localparam int MODEL_W = 3;

	// model codes
	localparam logic [MODEL_W-1:0] MODEL_STANDARD = 3'd0;
	localparam logic [MODEL_W-1:0] MODEL_ITU      = 3'd1;
	localparam logic [MODEL_W-1:0] MODEL_ROHC     = 3'd2;
	localparam logic [MODEL_W-1:0] MODEL_MAXIM    = 3'd3;
	localparam logic [MODEL_W-1:0] MODEL_NONE     = 3'd4;

	// configuration register indexes
	localparam logic REG_MODEL  = 1'b0;
	localparam logic REG_VERIFY = 1'b1;

	localparam logic [CRC_W-1:0] POLY_CCITT = 8'h07;
	localparam logic [CRC_W-1:0] POLY_MAXIM = 8'h31;
	localparam logic [CRC_W-1:0] XOR_ITU    = 8'h55;
	localparam logic [CRC_W-1:0] INIT_ROHC  = 8'hFF;
	localparam logic [CRC_W-1:0] CRC_MSB    = 8'h80;

	typedef struct packed {
		logic [CRC_W-1:0] poly;
		logic [CRC_W-1:0] init;
		logic [CRC_W-1:0] xorout;
		logic             reflect;
	} crc_model_t;

	// per-item control into the datapath
	typedef struct packed {
		logic             starting;
		logic             last;
		logic             verify;
		logic [MODEL_W-1:0] model;
	} dp_ctrl_t;

	// datapath results
	typedef struct packed {
		logic [CRC_W-1:0] crc_value;
		logic             crc_match;
		logic [CRC_W-1:0] running_next;
	} dp_result_t;

	function automatic crc_model_t model_lookup(input logic [MODEL_W-1:0] code);
		crc_model_t m;
		m = '{poly: '0, init: '0, xorout: '0, reflect: 1'b0};
		unique case (code)
			MODEL_STANDARD: m = '{poly: POLY_CCITT, init: '0, xorout: '0, reflect: 1'b0};
			MODEL_ITU:      m = '{poly: POLY_CCITT, init: '0, xorout: XOR_ITU, reflect: 1'b0};
			MODEL_ROHC:     m = '{poly: POLY_CCITT, init: INIT_ROHC, xorout: '0, reflect: 1'b1};
			MODEL_MAXIM:    m = '{poly: POLY_MAXIM, init: '0, xorout: '0, reflect: 1'b1};
			default:        m = '{poly: '0, init: '0, xorout: '0, reflect: 1'b0};
		endcase
		return m;
	endfunction

	function automatic logic [CRC_W-1:0] rev8(input logic [CRC_W-1:0] v);
		logic [CRC_W-1:0] r;
		for (int i = 0; i < CRC_W; i++) begin
			r[i] = v[CRC_W-1-i];
		end
		return r;
	endfunction

	// eight msb-first shifts of the crc register
	function automatic logic [CRC_W-1:0] shift8(input logic [CRC_W-1:0] c,
		input logic [CRC_W-1:0] poly);
		logic [CRC_W-1:0] r;
		r = c;
		for (int i = 0; i < CRC_W; i++) begin
			if ((r & CRC_MSB) != '0) begin
				r = {r[CRC_W-2:0], 1'b0} ^ poly;
			end else begin
				r = {r[CRC_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

>>> src/crc8mm_datapath.sv
// byte-wide crc update, finish and verify compare
module crc8mm_datapath
	import crc8mm_pkg::*;
(
	input  dp_ctrl_t         ctrl,
	input  logic [CRC_W-1:0] running_crc,
	input  logic [CRC_W-1:0] data_byte,
	output dp_result_t       res
);

	crc_model_t       m;
	logic [CRC_W-1:0] crc_start;
	logic [CRC_W-1:0] din;
	logic [CRC_W-1:0] crc_upd;
	logic [CRC_W-1:0] fin_upd;
	logic [CRC_W-1:0] fin_start;

	always_comb begin
		m         = model_lookup(ctrl.model);
		crc_start = ctrl.starting ? m.init : running_crc;
		din       = m.reflect ? rev8(data_byte) : data_byte;
		crc_upd   = shift8(crc_start ^ din, m.poly);
		fin_upd   = (m.reflect ? rev8(crc_upd) : crc_upd) ^ m.xorout;
		fin_start = (m.reflect ? rev8(crc_start) : crc_start) ^ m.xorout;

		if (ctrl.last && ctrl.verify) begin
			// final byte is the stored crc, not data
			res.running_next = crc_start;
			if (ctrl.starting) begin
				res.crc_value = '0;
				res.crc_match = 1'b0;
			end else begin
				res.crc_value = fin_start;
				res.crc_match = (fin_start == data_byte);
			end
		end else begin
			res.running_next = crc_upd;
			res.crc_value    = fin_upd;
			res.crc_match    = 1'b0;
		end
	end

endmodule

>>> src/crc8_multi_model_engine_core.sv
// top level of the crc-8 multi-model engine: item registers, crc state, result register
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata = data_byte, s_tlast = last_byte
//  m_*     | out | m_tvalid/m_tready  | m_tdata = crc_value, m_tuser = crc_match
//  cfg_*   | in  | cfg_wen            | cfg_index 0 model, 1 verify_mode
//
// one item per cycle sustained unless a held result stops a final byte; the byte-wide
// xor network between the input register and the result register also feeds the
// running crc register; a final byte goes via the input register to the result register
// a non-final item leaves the input register at once, so only a held result
// stops the input side, and only when a final byte is waiting behind it
// arst_n clears valids, message flag, running crc and configuration
module crc8_multi_model_engine_core
	import crc8mm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// slave item stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [CRC_W-1:0]   s_tdata,   // [7:0] data_byte
	input  logic               s_tlast,   // last_byte
	// master result stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [CRC_W-1:0]   m_tdata,   // [7:0] crc_value
	output logic               m_tuser,   // [0] crc_match
	// configuration writes
	input  logic               cfg_wen,
	input  logic               cfg_index,
	input  logic [MODEL_W-1:0] cfg_wdata
);

	// configuration registers
	logic [MODEL_W-1:0] model_q;
	logic               verify_mode_q;

	// input register
	logic               valid_s1;
	logic [CRC_W-1:0]   data_s1;
	logic               last_s1;

	// message state
	logic [CRC_W-1:0]   running_crc_q;
	logic               in_message_q;

	logic               advance;
	dp_ctrl_t           ctrl;
	dp_result_t         res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q       <= MODEL_STANDARD;
			verify_mode_q <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_MODEL:  model_q       <= cfg_wdata;
				REG_VERIFY: verify_mode_q <= cfg_wdata[0];
				default:    ;
			endcase
		end
	end

	// a final byte needs room in the result register
	assign advance  = valid_s1 && (!last_s1 || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign ctrl = '{starting: !in_message_q, last: last_s1, verify: verify_mode_q,
		model: model_q};

	crc8mm_datapath u_datapath (
		.ctrl        (ctrl),
		.running_crc (running_crc_q),
		.data_byte   (data_s1),
		.res         (res)
	);

	// running crc and the start-of-message flag move with each item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= '0;
			in_message_q  <= 1'b0;
		end else if (advance) begin
			running_crc_q <= res.running_next;
			in_message_q  <= !last_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance && last_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			m_tdata <= res.crc_value;
			m_tuser <= res.crc_match;
		end
	end

`include "crc8_multi_model_engine_core_macros.svh"

	// a data byte leaves the block inside a message
	`CRC8MM_ASSERT_NEXT(a_mid_msg, advance && !last_s1, in_message_q && !$rose(m_tvalid))
	// a final byte closes the message and posts a result
	`CRC8MM_ASSERT_NEXT(a_last_result, advance && last_s1, m_tvalid && !in_message_q)
	// the input side only stalls behind a held result
	`CRC8MM_ASSERT_IMP(a_stall_cause, valid_s1 && !s_tready, last_s1 && m_tvalid && !m_tready)

endmodule

>>> tb/crc8_multi_model_engine_checker.sv
// crc-8 engine checker: tracks configuration and items, predicts results and compares them
module crc8_multi_model_engine_checker
	import crc8mm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [CRC_W-1:0]   s_tdata,   // [7:0] data_byte
	input  logic               s_tlast,   // last_byte
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [CRC_W-1:0]   m_tdata,   // [7:0] crc_value
	input  logic               m_tuser,   // [0] crc_match
	input  logic               cfg_wen,
	input  logic               cfg_index,
	input  logic [MODEL_W-1:0] cfg_wdata,
	output int                 mismatches,
	output int                 owed,
	output logic [CRC_W-1:0]   msg_crc    // finished crc of the bytes taken so far
);

	typedef struct packed {
		logic [CRC_W-1:0] crc;
		logic             match;
	} crc_outcome_t;

	crc_outcome_t       awaited_crcs[$];
	logic [MODEL_W-1:0] cur_model;
	logic               cur_verify;
	logic [CRC_W-1:0]   run_crc;
	logic               in_msg;

	function automatic crc_model_t variant_params(input logic [MODEL_W-1:0] code);
		crc_model_t p;
		p.poly    = '0;
		p.init    = '0;
		p.xorout  = '0;
		p.reflect = 1'b0;
		case (code)
			MODEL_STANDARD: p.poly = POLY_CCITT;
			MODEL_ITU: begin
				p.poly   = POLY_CCITT;
				p.xorout = XOR_ITU;
			end
			MODEL_ROHC: begin
				p.poly    = POLY_CCITT;
				p.init    = INIT_ROHC;
				p.reflect = 1'b1;
			end
			MODEL_MAXIM: begin
				p.poly    = POLY_MAXIM;
				p.reflect = 1'b1;
			end
			default: ;
		endcase
		return p;
	endfunction

	function automatic logic [CRC_W-1:0] flip8(input logic [CRC_W-1:0] v);
		logic [CRC_W-1:0] r;
		r = '0;
		for (int i = 0; i < CRC_W; i++) begin
			r = {r[CRC_W-2:0], v[i]};
		end
		return r;
	endfunction

	function automatic logic [CRC_W-1:0] crc_absorb(input crc_model_t p,
		input logic [CRC_W-1:0] crc, input logic [CRC_W-1:0] d);
		logic [CRC_W-1:0] r;
		r = crc ^ (p.reflect ? flip8(d) : d);
		for (int i = 0; i < CRC_W; i++) begin
			r = r[CRC_W-1] ? ({r[CRC_W-2:0], 1'b0} ^ p.poly) : {r[CRC_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [CRC_W-1:0] crc_finish(input crc_model_t p,
		input logic [CRC_W-1:0] crc);
		return (p.reflect ? flip8(crc) : crc) ^ p.xorout;
	endfunction

	assign msg_crc = crc_finish(variant_params(cur_model), run_crc);

	task report_mismatch(input string what);
		$display("[%0t] %s", $realtime, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		crc_model_t   prm;
		logic [CRC_W-1:0] acc;
		logic [CRC_W-1:0] fin;
		crc_outcome_t got;
		int           delta;
		if (!arst_n) begin
			awaited_crcs.delete();
			mismatches = 0;
			owed       <= 0;
			cur_model  <= MODEL_STANDARD;
			cur_verify <= 1'b0;
			run_crc    <= '0;
			in_msg     <= 1'b0;
		end else begin
			delta = 0;
			if (m_tvalid && m_tready) begin
				if (awaited_crcs.size() == 0) begin
					report_mismatch($sformatf("unexpected result: crc_value %02h crc_match %0b",
						m_tdata, m_tuser));
				end else begin
					got = awaited_crcs.pop_front();
					delta--;
					if (m_tdata !== got.crc)
						report_mismatch($sformatf("crc_value: got %02h, expected %02h",
							m_tdata, got.crc));
					if (m_tuser !== got.match)
						report_mismatch($sformatf("crc_match: got %0b, expected %0b",
							m_tuser, got.match));
				end
			end
			if (s_tvalid && s_tready) begin
				prm = variant_params(cur_model);
				// init is loaded only on the first byte of a message
				acc = in_msg ? run_crc : prm.init;
				if (!s_tlast) begin
					run_crc <= crc_absorb(prm, acc, s_tdata);
					in_msg  <= 1'b1;
				end else begin
					in_msg <= 1'b0;
					if (cur_verify) begin
						run_crc <= acc;
						if (!in_msg) begin
							// lone stored byte, nothing to check against
							awaited_crcs.push_back('{crc: '0, match: 1'b0});
						end else begin
							fin = crc_finish(prm, acc);
							awaited_crcs.push_back('{crc: fin, match: (fin == s_tdata)});
						end
					end else begin
						acc     = crc_absorb(prm, acc, s_tdata);
						run_crc <= acc;
						awaited_crcs.push_back('{crc: crc_finish(prm, acc), match: 1'b0});
					end
					delta++;
				end
			end
			if (cfg_wen) begin
				if (cfg_index == REG_MODEL)
					cur_model <= cfg_wdata;
				else
					cur_verify <= cfg_wdata[0];
			end
			owed <= owed + delta;
		end
	end

endmodule

>>> tb/crc8_multi_model_engine_core_tb.sv
// crc-8 engine testbench top: clock, reset, item and configuration stimulus, verdict
module crc8_multi_model_engine_core_tb;
	import crc8mm_pkg::*;

	localparam int RANDOM_ITEMS   = 1200;
	localparam int SETTLE_CYCLES  = 6;     // settle margin after the last result is out
	localparam int WATCHDOG_LIMIT = 5000;
	// highest code of the model field, an unused one that acts as model none
	localparam logic [MODEL_W-1:0] MODEL_TOP_CODE = '1;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_CHOKED,
		RX_PERIODIC
	} rx_mode_e;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [CRC_W-1:0]   s_tdata   = '0;
	logic               s_tlast   = 1'b0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [CRC_W-1:0]   m_tdata;
	logic               m_tuser;
	logic               cfg_wen   = 1'b0;
	logic               cfg_index = 1'b0;
	logic [MODEL_W-1:0] cfg_wdata = '0;

	int                 mismatches;
	int                 owed;
	logic [CRC_W-1:0]   msg_crc;

	// stimulus bookkeeping
	int                 items_sent = 0;
	int                 burst_left = 0;
	logic               cur_verify = 1'b0;

	// receiver pattern state
	rx_mode_e           rx_mode  = RX_OPEN;
	int                 rx_left  = 0;
	logic [7:0]         rx_phase = '0;

	crc8_multi_model_engine_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	crc8_multi_model_engine_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.owed       (owed),
		.msg_crc    (msg_crc)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: each pattern holds for a random stretch, open stretches included
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_e'($urandom_range(0, 3));
			rx_left <= $urandom_range(16, 96);
		end else begin
			rx_left <= rx_left - 1;
		end
		rx_phase <= rx_phase + 8'd1;
		case (rx_mode)
			RX_OPEN:     m_tready <= 1'b1;
			RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
			RX_CHOKED:   m_tready <= ($urandom_range(0, 3) == 0);
			RX_PERIODIC: m_tready <= rx_phase[2];
			default:     m_tready <= 1'b1;
		endcase
	end

	// watchdog: too many cycles without any handshake or write ends the run
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	// mostly random bytes, with the all-zero and all-one extremes mixed in
	function automatic logic [CRC_W-1:0] rand_byte();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return CRC_W'($urandom_range(0, 255));
		endcase
	endfunction

	// one item on the slave side; a gap may open in front of it when a burst runs out
	task send_byte(input logic [CRC_W-1:0] d, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// final byte of a verify message: drop valid first so the running crc of
	// the bytes just taken is visible, then send it or a corrupted copy
	task send_stored(input bit matched);
		logic [CRC_W-1:0] d;
		s_tvalid <= 1'b0;
		@(posedge clk);
		d = msg_crc;
		if (!matched)
			d = d ^ CRC_W'($urandom_range(1, 255));
		send_byte(d, 1'b1);
	endtask

	// one random message: mostly short, some single bytes, a few long ones
	task send_message();
		int len;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			len = 1;
		else if (pick == 1)
			len = $urandom_range(9, 24);
		else
			len = $urandom_range(2, 8);
		for (int i = 0; i < len - 1; i++)
			send_byte(rand_byte(), 1'b0);
		pick = $urandom_range(0, 9);
		if (cur_verify && len > 1 && pick < 6)
			send_stored(1'b1);
		else if (cur_verify && len > 1 && pick < 8)
			send_stored(1'b0);
		else
			send_byte(rand_byte(), 1'b1);
	endtask

	// drop valid and wait until every result is out and the block has gone quiet
	task drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (owed != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers on back-to-back cycles; spare data bits are random
	task set_variant(input logic [MODEL_W-1:0] code, input logic verify);
		logic [MODEL_W-1:0] wv;
		wv    = MODEL_W'($urandom_range(0, (1 << MODEL_W) - 1));
		wv[0] = verify;
		cfg_wen   <= 1'b1;
		cfg_index <= REG_MODEL;
		cfg_wdata <= code;
		@(posedge clk);
		cfg_index <= REG_VERIFY;
		cfg_wdata <= wv;
		@(posedge clk);
		cfg_wen    <= 1'b0;
		cur_verify = verify;
	endtask

	initial begin : stimulus
		int stop_at;
		int quota;
		int phase_no;
		logic [MODEL_W-1:0] code;
		logic verify;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, standard model computing
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hFF, 1'b1);
		drain();

		// reflected model with nonzero init
		set_variant(MODEL_ROHC, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hA5, 1'b1);
		drain();

		// verify: lone stored byte, a match, a mismatch
		set_variant(MODEL_MAXIM, 1'b1);
		send_byte(8'h5A, 1'b1);
		send_byte(8'h31, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_stored(1'b1);
		send_byte(8'h00, 1'b0);
		send_stored(1'b0);
		drain();

		// final xor model
		set_variant(MODEL_ITU, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_stored(1'b1);
		drain();

		// unused model code behaves as model none
		set_variant(MODEL_TOP_CODE, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'hFF, 1'b1);
		drain();

		set_variant(MODEL_NONE, 1'b1);
		send_byte(8'hAB, 1'b0);
		send_stored(1'b1);
		drain();

		set_variant(MODEL_STANDARD, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_stored(1'b0);
		drain();

		// random: first a sweep over every model code in both modes, then random settings
		stop_at  = items_sent + RANDOM_ITEMS;
		phase_no = 0;
		while (items_sent < stop_at) begin
			if (phase_no < 2 * (1 << MODEL_W)) begin
				code   = MODEL_W'(phase_no >> 1);
				verify = phase_no[0];
			end else begin
				code   = MODEL_W'($urandom_range(0, (1 << MODEL_W) - 1));
				verify = 1'($urandom_range(0, 1));
			end
			set_variant(code, verify);
			quota = items_sent + $urandom_range(40, 80);
			while (items_sent < quota)
				send_message();
			drain();
			phase_no++;
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
